FILE: rtl/sbr_pkg.sv
// shared constants for the scenario backward reduction block
// field widths, item kinds, error codes and default sizes; no dependencies
`timescale 1ns / 1ps
package sbr_pkg;

	localparam int MEMBERS_DEF = 32;
	localparam int STEPS_DEF   = 64;

	localparam int KIND_W   = 2;
	localparam int MEMBER_W = 6;
	localparam int STEP_W   = 6;
	localparam int SAMPLE_W = 32;
	localparam int PROB_W   = 17;
	localparam int COUNT_W  = 7;
	localparam int ERR_W    = 2;

	localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PROB   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RUN    = 2'd2;

	localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
	localparam logic [ERR_W-1:0] ERR_NO_SURV = 2'd1;
	localparam logic [ERR_W-1:0] ERR_NO_CAND = 2'd2;

	localparam logic [PROB_W-1:0] PROB_ONE = 17'h10000;

endpackage

FILE: rtl/sbr_cmd_if.sv
// input channel of the scenario backward reduction block
// valid/ready handshake with load and run fields; uses sbr_pkg
`timescale 1ns / 1ps
interface sbr_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [sbr_pkg::KIND_W-1:0]          kind;
	logic [sbr_pkg::MEMBER_W-1:0]        member;
	logic [sbr_pkg::STEP_W-1:0]          step_index;
	logic signed [sbr_pkg::SAMPLE_W-1:0] sample_value;
	logic [sbr_pkg::PROB_W-1:0]          probability_in;
	logic [sbr_pkg::COUNT_W-1:0]         window_steps;
	logic [sbr_pkg::COUNT_W-1:0]         keep_count;

	modport source(output valid, kind, member, step_index, sample_value, probability_in,
		window_steps, keep_count, input ready);
	modport sink(input valid, kind, member, step_index, sample_value, probability_in,
		window_steps, keep_count, output ready);
endinterface

FILE: rtl/sbr_res_if.sv
// result channel of the scenario backward reduction block
// valid/ready handshake with per-member result fields; uses sbr_pkg
`timescale 1ns / 1ps
interface sbr_res_if;
	logic                         valid;
	logic                         ready;
	logic [sbr_pkg::MEMBER_W-1:0] member_out;
	logic [sbr_pkg::MEMBER_W-1:0] representative;
	logic [sbr_pkg::PROB_W-1:0]   probability_out;
	logic [sbr_pkg::ERR_W-1:0]    error_code;
	logic                         last;

	modport source(output valid, member_out, representative, probability_out, error_code,
		last, input ready);
	modport sink(input valid, member_out, representative, probability_out, error_code,
		last, output ready);
endinterface

FILE: rtl/sbr_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
module sbr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/scenario_backward_reduction.sv
// Backward scenario reduction over an ensemble. Load items (samples, probabilities) are taken one
// per cycle while idle. A run item first sets up every member, then builds the L1 distance table
// (two sample ram copies, one step of one member pair per cycle) and drains that pipeline, then
// runs greedy deletion passes (one distance ram read per cycle) until enough members are deleted
// or no candidate is left, then a redistribution pass per deleted member, and finally emits
// MEMBERS result items, one per cycle while the sink is ready. No input item is taken from the
// run item until the last result item sits in the output register.
// depends on sbr_pkg, sbr_cmd_if, sbr_res_if and sbr_ram
`timescale 1ns / 1ps
module scenario_backward_reduction #(
	parameter int MEMBERS = sbr_pkg::MEMBERS_DEF,
	parameter int STEPS   = sbr_pkg::STEPS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	sbr_cmd_if.sink  cmd,
	sbr_res_if.source res
);
	localparam int MW  = $clog2(MEMBERS);
	localparam int SW  = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int WW  = $clog2(STEPS + 1);
	localparam int SAW = $clog2(MEMBERS * STEPS);
	localparam int DAW = $clog2(MEMBERS * MEMBERS);
	localparam int DW  = 33 + $clog2(STEPS);
	localparam int PW  = sbr_pkg::PROB_W;
	localparam int ZW  = PW + DW;
	localparam int CW  = $clog2(MEMBERS + 1);
	localparam int OMW = sbr_pkg::MEMBER_W;
	localparam logic [MW-1:0] LAST_M = MW'(MEMBERS - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_DIST, S_DDRAIN, S_GSCAN, S_GDRAIN, S_GDEC,
		S_RSTART, S_RSCAN, S_RDRAIN, S_RAPPLY1, S_RAPPLY2, S_EMIT
	} state_t;

	state_t state_q;
	logic [WW-1:0] win_q;
	logic [sbr_pkg::COUNT_W-1:0] keep_q;
	logic [CW-1:0] ntree_q, todo_q, ndel_q;
	logic [sbr_pkg::ERR_W-1:0] err_q;
	logic [MW-1:0] i_q, a_q, b_q;
	logic [SW-1:0] k_q;

	logic [PW-1:0] prob_q [MEMBERS];
	logic [MW-1:0] rep_q [MEMBERS];
	logic [MW-1:0] order_q [MEMBERS];
	logic [MEMBERS-1:0] nz_q, del_q;

	logic dv_s1, dfirst_s1, dlast_s1, dzero_s1;
	logic [MW-1:0] da_s1, db_s1;
	logic dv_s2, dfirst_s2, dlast_s2;
	logic [MW-1:0] da_s2, db_s2;
	logic [32:0] diff_s2;
	logic [DW-1:0] acc_q;

	logic sv_s1, sfirst_s1, slast_s1, scand_s1, sgreedy_s1;
	logic [MW-1:0] sl_s1, sj_s1;
	logic have_q;
	logic [DW-1:0] dmin_q;
	logic [MW-1:0] idx_q;
	logic gv_s2, gv_s3;
	logic [MW-1:0] gl_s2, gl_s3;
	logic [DW-1:0] gmin_s2;
	logic [ZW-1:0] gz_s3;
	logic best_have_q;
	logic [MW-1:0] best_q;
	logic [ZW-1:0] best_z_q;
	logic [PW-1:0] pg_q;

	logic ov_q, olast_q;
	logic [OMW-1:0] om_q, orep_q;
	logic [PW-1:0] op_q;
	logic [sbr_pkg::ERR_W-1:0] oerr_q;

	logic accept, load_ok;
	logic [SAW-1:0] s_waddr, s_raddr_a, s_raddr_b;
	logic [31:0] sa_rd, sb_rd;
	logic [DAW-1:0] d_waddr, d_raddr;
	logic [DW-1:0] d_wdata, dist_rd;
	logic d_we;
	logic wlast;
	logic [32:0] df, ab;
	logic hb, take, nh;
	logic [DW-1:0] nm;
	logic [MW-1:0] ni;
	logic [MW-1:0] prd_idx;
	logic [PW-1:0] prob_rd;
	logic [PW:0] psum;
	logic [CW-1:0] todo_c;
	logic cand_c;

	assign cmd.ready = (state_q == S_IDLE);
	assign accept = cmd.valid && cmd.ready;
	assign load_ok = (int'(cmd.member) < MEMBERS) && (int'(cmd.step_index) < STEPS);

	assign s_waddr   = SAW'(cmd.member) * SAW'(STEPS) + SAW'(cmd.step_index);
	assign s_raddr_a = SAW'(a_q) * SAW'(STEPS) + SAW'(k_q);
	assign s_raddr_b = SAW'(b_q) * SAW'(STEPS) + SAW'(k_q);

	sbr_ram #(.WIDTH(32), .DEPTH(MEMBERS * STEPS)) u_samp_a (
		.clk(clk), .we(accept && cmd.kind == sbr_pkg::KIND_SAMPLE && load_ok),
		.waddr(s_waddr), .wdata(cmd.sample_value), .raddr(s_raddr_a), .rdata(sa_rd));
	sbr_ram #(.WIDTH(32), .DEPTH(MEMBERS * STEPS)) u_samp_b (
		.clk(clk), .we(accept && cmd.kind == sbr_pkg::KIND_SAMPLE && load_ok),
		.waddr(s_waddr), .wdata(cmd.sample_value), .raddr(s_raddr_b), .rdata(sb_rd));

	assign d_we    = dv_s2 && dlast_s2;
	assign d_waddr = DAW'(da_s2) * DAW'(MEMBERS) + DAW'(db_s2);
	assign d_wdata = (dfirst_s2 ? '0 : acc_q) + DW'(diff_s2);
	assign d_raddr = DAW'(a_q) * DAW'(MEMBERS) + DAW'(b_q);

	sbr_ram #(.WIDTH(DW), .DEPTH(MEMBERS * MEMBERS)) u_dist (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .raddr(d_raddr),
		.rdata(dist_rd));

	always_comb begin
		wlast = (win_q == '0) || (WW'(k_q) == win_q - WW'(1));
		df = {sa_rd[31], sa_rd} - {sb_rd[31], sb_rd};
		ab = df[32] ? (33'd0 - df) : df;
		hb = sfirst_s1 ? 1'b0 : have_q;
		take = scand_s1 && (!hb || dist_rd < dmin_q);
		nh = hb || scand_s1;
		nm = take ? dist_rd : dmin_q;
		ni = take ? sj_s1 : idx_q;
		if (gv_s2) begin
			prd_idx = gl_s2;
		end else if (state_q == S_RAPPLY1) begin
			prd_idx = a_q;
		end else if (state_q == S_RAPPLY2) begin
			prd_idx = idx_q;
		end else begin
			prd_idx = i_q;
		end
		prob_rd = prob_q[prd_idx];
		psum = {1'b0, prob_rd} + {1'b0, pg_q};
		todo_c = (8'(ntree_q) > 8'(keep_q)) ? CW'(8'(ntree_q) - 8'(keep_q)) : '0;
		if (state_q == S_GSCAN) begin
			cand_c = nz_q[a_q] && !del_q[a_q] && (b_q != a_q) && !del_q[b_q];
		end else begin
			cand_c = (b_q != a_q) && !del_q[b_q] && nz_q[b_q];
		end
	end

	// datapath pipeline registers
	always_ff @(posedge clk) begin
		dfirst_s1 <= (k_q == '0);
		dlast_s1 <= wlast;
		dzero_s1 <= (win_q == '0);
		da_s1 <= a_q;
		db_s1 <= b_q;
		dfirst_s2 <= dfirst_s1;
		dlast_s2 <= dlast_s1;
		da_s2 <= da_s1;
		db_s2 <= db_s1;
		diff_s2 <= dzero_s1 ? '0 : ab;
		if (dv_s2) begin
			acc_q <= d_wdata;
		end
		sfirst_s1 <= (b_q == '0);
		slast_s1 <= (b_q == LAST_M);
		scand_s1 <= cand_c;
		sgreedy_s1 <= (state_q == S_GSCAN);
		sl_s1 <= a_q;
		sj_s1 <= b_q;
		if (sv_s1) begin
			have_q <= nh;
			dmin_q <= nm;
			idx_q <= ni;
		end
		gl_s2 <= sl_s1;
		gmin_s2 <= nm;
		gl_s3 <= gl_s2;
		gz_s3 <= ZW'(prob_rd) * ZW'(gmin_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			win_q <= '0;
			keep_q <= '0;
			ntree_q <= '0;
			todo_q <= '0;
			ndel_q <= '0;
			err_q <= sbr_pkg::ERR_OK;
			i_q <= '0;
			a_q <= '0;
			b_q <= '0;
			k_q <= '0;
			nz_q <= '0;
			del_q <= '0;
			dv_s1 <= 1'b0;
			dv_s2 <= 1'b0;
			sv_s1 <= 1'b0;
			gv_s2 <= 1'b0;
			gv_s3 <= 1'b0;
			best_have_q <= 1'b0;
			best_q <= '0;
			best_z_q <= '0;
			pg_q <= '0;
			ov_q <= 1'b0;
			olast_q <= 1'b0;
			om_q <= '0;
			orep_q <= '0;
			op_q <= '0;
			oerr_q <= sbr_pkg::ERR_OK;
		end else begin
			dv_s1 <= (state_q == S_DIST);
			dv_s2 <= dv_s1;
			sv_s1 <= (state_q == S_GSCAN) || (state_q == S_RSCAN);
			gv_s2 <= sv_s1 && sgreedy_s1 && slast_s1 && nh;
			gv_s3 <= gv_s2;
			if (gv_s3 && (!best_have_q || gz_s3 < best_z_q)) begin
				best_have_q <= 1'b1;
				best_q <= gl_s3;
				best_z_q <= gz_s3;
			end
			ov_q <= (state_q == S_EMIT) ? 1'b1 : (ov_q && !res.ready);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority if (cmd.kind == sbr_pkg::KIND_PROB) begin
							if (int'(cmd.member) < MEMBERS) begin
								prob_q[MW'(cmd.member)] <= cmd.probability_in;
								nz_q[MW'(cmd.member)] <= (cmd.probability_in != '0);
							end
						end else if (cmd.kind == sbr_pkg::KIND_RUN) begin
							win_q <= (int'(cmd.window_steps) > STEPS) ? WW'(STEPS)
								: WW'(cmd.window_steps);
							keep_q <= cmd.keep_count;
							ntree_q <= '0;
							ndel_q <= '0;
							err_q <= sbr_pkg::ERR_OK;
							i_q <= '0;
							state_q <= S_INIT;
						end else begin
						end
					end
				end
				S_INIT: begin
					rep_q[i_q] <= i_q;
					del_q[i_q] <= 1'b0;
					ntree_q <= ntree_q + CW'(nz_q[i_q]);
					if (i_q == LAST_M) begin
						i_q <= '0;
						a_q <= '0;
						b_q <= '0;
						k_q <= '0;
						state_q <= S_DIST;
					end else begin
						i_q <= i_q + MW'(1);
					end
				end
				S_DIST: begin
					todo_q <= todo_c;
					if (wlast) begin
						k_q <= '0;
						if (b_q == LAST_M) begin
							b_q <= '0;
							if (a_q == LAST_M) begin
								state_q <= S_DDRAIN;
							end else begin
								a_q <= a_q + MW'(1);
							end
						end else begin
							b_q <= b_q + MW'(1);
						end
					end else begin
						k_q <= k_q + SW'(1);
					end
				end
				S_DDRAIN: begin
					if (!dv_s1 && !dv_s2) begin
						a_q <= '0;
						b_q <= '0;
						best_have_q <= 1'b0;
						if (ndel_q < todo_q) begin
							state_q <= S_GSCAN;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_GSCAN: begin
					if (b_q == LAST_M) begin
						b_q <= '0;
						if (a_q == LAST_M) begin
							state_q <= S_GDRAIN;
						end else begin
							a_q <= a_q + MW'(1);
						end
					end else begin
						b_q <= b_q + MW'(1);
					end
				end
				S_GDRAIN: begin
					if (!sv_s1 && !gv_s2 && !gv_s3) begin
						state_q <= S_GDEC;
					end
				end
				S_GDEC: begin
					a_q <= '0;
					b_q <= '0;
					i_q <= '0;
					if (best_have_q) begin
						del_q[best_q] <= 1'b1;
						order_q[MW'(ndel_q)] <= best_q;
						ndel_q <= ndel_q + CW'(1);
						best_have_q <= 1'b0;
						if (ndel_q + CW'(1) < todo_q) begin
							state_q <= S_GSCAN;
						end else begin
							state_q <= S_RSTART;
						end
					end else begin
						err_q <= sbr_pkg::ERR_NO_CAND;
						state_q <= (ndel_q == '0) ? S_EMIT : S_RSTART;
					end
				end
				S_RSTART: begin
					a_q <= order_q[i_q];
					b_q <= '0;
					state_q <= S_RSCAN;
				end
				S_RSCAN: begin
					if (b_q == LAST_M) begin
						b_q <= '0;
						state_q <= S_RDRAIN;
					end else begin
						b_q <= b_q + MW'(1);
					end
				end
				S_RDRAIN: begin
					if (!sv_s1) begin
						state_q <= S_RAPPLY1;
					end
				end
				S_RAPPLY1: begin
					if (have_q) begin
						pg_q <= prob_rd;
						state_q <= S_RAPPLY2;
					end else begin
						if (err_q == sbr_pkg::ERR_OK) begin
							err_q <= sbr_pkg::ERR_NO_SURV;
						end
						if (CW'(i_q) + CW'(1) == ndel_q) begin
							i_q <= '0;
							state_q <= S_EMIT;
						end else begin
							i_q <= i_q + MW'(1);
							state_q <= S_RSTART;
						end
					end
				end
				S_RAPPLY2: begin
					prob_q[idx_q] <= (psum > {1'b0, sbr_pkg::PROB_ONE}) ? sbr_pkg::PROB_ONE
						: psum[PW-1:0];
					prob_q[a_q] <= '0;
					nz_q[a_q] <= 1'b0;
					for (int m = 0; m < MEMBERS; m++) begin
						if (rep_q[m] == a_q) begin
							rep_q[m] <= idx_q;
						end
					end
					if (CW'(i_q) + CW'(1) == ndel_q) begin
						i_q <= '0;
						state_q <= S_EMIT;
					end else begin
						i_q <= i_q + MW'(1);
						state_q <= S_RSTART;
					end
				end
				S_EMIT: begin
					if (!ov_q || res.ready) begin
						om_q <= OMW'(i_q);
						orep_q <= OMW'(rep_q[i_q]);
						op_q <= prob_rd;
						oerr_q <= err_q;
						olast_q <= (i_q == LAST_M);
						if (i_q == LAST_M) begin
							i_q <= '0;
							state_q <= S_IDLE;
						end else begin
							i_q <= i_q + MW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res.valid = ov_q;
	assign res.member_out = om_q;
	assign res.representative = orep_q;
	assign res.probability_out = op_q;
	assign res.error_code = oerr_q;
	assign res.last = olast_q;

	a_pass_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GSCAN) |-> (ndel_q < todo_q))
		else $error("greedy pass started with no deletion left");
	a_fresh_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GDEC && best_have_q) |-> !del_q[best_q])
		else $error("selected member already deleted");
	a_live_survivor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RAPPLY2) |-> (idx_q != a_q && !del_q[idx_q]))
		else $error("probability moved to an invalid survivor");
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !(dv_s1 || dv_s2 || sv_s1 || gv_s2 || gv_s3))
		else $error("pipeline busy while idle");

endmodule
